// File: design/slu_pkg.sv
// shared types and constants for the string literal unescape block
// no dependencies; used by every module of the block
package slu_pkg;

	// result status codes
	typedef enum logic [2:0] {
		ST_OK      = 3'd0,
		ST_UNKNOWN = 3'd1,
		ST_DIGIT   = 3'd2,
		ST_LARGE   = 3'd3,
		ST_UNTERM  = 3'd4
	} status_t;

	// one input item
	typedef struct packed {
		logic [7:0] in_byte;
		logic       end_of_literal;
	} in_item_t;

	// one result item
	typedef struct packed {
		logic [7:0] out_byte;
		logic       last_of_run;
		status_t    status;
	} out_item_t;

	// all results of one input item, as handed from front to back
	typedef struct packed {
		logic [3:0][7:0] bytes;
		logic [1:0]      last_idx;
		status_t         status;
	} job_t;

	// job queue geometry, depth a power of two
	localparam int QDepth = 4;
	localparam int QPtrW  = $clog2(QDepth);
	localparam int QCntW  = $clog2(QDepth + 1);

endpackage

// File: design/slu_front.sv
// front end: escape parser state machine, turns each item into a job
// depends on slu_pkg
module slu_front (
	input  logic              clk,
	input  logic              arst_n,
	input  logic              in_valid,
	output logic              in_ready,
	input  slu_pkg::in_item_t in_item,
	input  logic              q_full,
	output logic              push,
	output slu_pkg::job_t     job
);

	typedef enum logic [3:0] {
		M_PLAIN, M_ESC, M_HEXA, M_HEXB, M_OCTB, M_OCTC,
		M_U4FIRST, M_U4DIG, M_U8FIRST, M_U8DIG, M_BRACED
	} mode_t;

	localparam logic [7:0] CH_BSLASH = 8'h5c;
	localparam logic [7:0] CH_DQUOTE = 8'h22;
	localparam logic [7:0] CH_SQUOTE = 8'h27;
	localparam logic [7:0] CH_LBRACE = 8'h7b;
	localparam logic [7:0] CH_RBRACE = 8'h7d;
	localparam logic [7:0] CH_ESCAPE = 8'h1b;
	localparam logic [23:0] MAX_CODE = 24'h10ffff;

	mode_t       mode_q, mode_d;
	logic [23:0] acc_q, acc_d;
	logic [3:0]  cnt_q, cnt_d;
	logic        ovf_q, ovf_d;

	logic       fire;
	logic [7:0] b;
	logic       hok;
	logic [3:0] hv;
	logic [23:0] hacc;
	logic [3:0]  hcnt;
	logic        hovf;

	// code point to utf-8, or a too-large status
	function automatic slu_pkg::job_t encode(input logic [23:0] m, input logic ovf);
		slu_pkg::job_t j;
		j = '0;
		if (ovf || m > MAX_CODE) begin
			j.status = slu_pkg::ST_LARGE;
		end else if (m <= 24'h7f) begin
			j.bytes[0] = m[7:0];
		end else if (m <= 24'h7ff) begin
			j.bytes[0] = {3'b110, m[10:6]};
			j.bytes[1] = {2'b10, m[5:0]};
			j.last_idx = 2'd1;
		end else if (m <= 24'hffff) begin
			j.bytes[0] = {4'b1110, m[15:12]};
			j.bytes[1] = {2'b10, m[11:6]};
			j.bytes[2] = {2'b10, m[5:0]};
			j.last_idx = 2'd2;
		end else begin
			j.bytes[0] = {5'b11110, m[20:18]};
			j.bytes[1] = {2'b10, m[17:12]};
			j.bytes[2] = {2'b10, m[11:6]};
			j.bytes[3] = {2'b10, m[5:0]};
			j.last_idx = 2'd3;
		end
		return j;
	endfunction

	assign in_ready = !q_full;
	assign fire     = in_valid && in_ready;
	assign b        = in_item.in_byte;

	// hex digit decode
	always_comb begin
		hok = 1'b1;
		hv  = 4'd0;
		if (b inside {[8'h30:8'h39]}) begin
			hv = b[3:0];
		end else if (b inside {[8'h41:8'h46], [8'h61:8'h66]}) begin
			hv = b[3:0] + 4'd9;
		end else begin
			hok = 1'b0;
		end
	end

	// accumulator after one more hex digit
	assign hacc = {acc_q[19:0], hv};
	assign hcnt = (cnt_q != 4'hf) ? cnt_q + 4'd1 : cnt_q;
	assign hovf = ovf_q || (acc_q[23:20] != 4'd0);

	always_comb begin
		mode_d = mode_q;
		acc_d  = acc_q;
		cnt_d  = cnt_q;
		ovf_d  = ovf_q;
		job    = '0;
		push   = 1'b0;
		if (in_item.end_of_literal) begin
			mode_d = M_PLAIN;
			acc_d  = '0;
			cnt_d  = '0;
			ovf_d  = 1'b0;
			if (mode_q == M_OCTB || mode_q == M_OCTC) begin
				job.bytes[0] = acc_q[7:0];
				push = 1'b1;
			end else if (mode_q != M_PLAIN) begin
				job.status = slu_pkg::ST_UNTERM;
				push = 1'b1;
			end
		end else begin
			case (mode_q)
				M_ESC: begin
					mode_d = M_PLAIN;
					acc_d  = '0;
					cnt_d  = '0;
					ovf_d  = 1'b0;
					push   = 1'b1;
					case (b)
						8'h78, 8'h58: begin
							mode_d = M_HEXA;
							push = 1'b0;
						end
						8'h30, 8'h31, 8'h32, 8'h33: begin
							acc_d  = {22'd0, b[1:0]};
							mode_d = M_OCTB;
							push = 1'b0;
						end
						8'h75: begin
							mode_d = M_U4FIRST;
							push = 1'b0;
						end
						8'h55: begin
							mode_d = M_U8FIRST;
							push = 1'b0;
						end
						8'h61: job.bytes[0] = 8'h07;
						8'h62: job.bytes[0] = 8'h08;
						8'h65: job.bytes[0] = CH_ESCAPE;
						8'h66: job.bytes[0] = 8'h0c;
						8'h6e: job.bytes[0] = 8'h0a;
						8'h72: job.bytes[0] = 8'h0d;
						8'h74: job.bytes[0] = 8'h09;
						8'h76: job.bytes[0] = 8'h0b;
						CH_DQUOTE, CH_SQUOTE, CH_BSLASH: job.bytes[0] = b;
						default: job.status = slu_pkg::ST_UNKNOWN;
					endcase
				end
				M_HEXA: begin
					if (!hok) begin
						job.status = slu_pkg::ST_DIGIT;
						push = 1'b1;
						mode_d = M_PLAIN;
						acc_d  = '0;
					end else begin
						acc_d  = {20'd0, hv};
						mode_d = M_HEXB;
					end
				end
				M_HEXB: begin
					push   = 1'b1;
					mode_d = M_PLAIN;
					acc_d  = '0;
					if (!hok) begin
						job.status = slu_pkg::ST_DIGIT;
					end else begin
						job.bytes[0] = {acc_q[3:0], hv};
					end
				end
				M_OCTB, M_OCTC: begin
					if (b inside {[8'h30:8'h37]}) begin
						acc_d = {acc_q[20:0], b[2:0]};
						if (mode_q == M_OCTB) begin
							mode_d = M_OCTC;
						end else begin
							job.bytes[0] = {acc_q[4:0], b[2:0]};
							push   = 1'b1;
							mode_d = M_PLAIN;
							acc_d  = '0;
						end
					end else begin
						// octal value, then the ending byte as plain text
						job.bytes[0] = acc_q[7:0];
						push  = 1'b1;
						acc_d = '0;
						if (b == CH_BSLASH) begin
							mode_d = M_ESC;
						end else begin
							job.bytes[1] = b;
							job.last_idx = 2'd1;
							mode_d = M_PLAIN;
						end
					end
				end
				M_U4FIRST, M_U8FIRST: begin
					acc_d = '0;
					cnt_d = '0;
					ovf_d = 1'b0;
					if (b == CH_LBRACE) begin
						mode_d = M_BRACED;
					end else if (!hok) begin
						job.status = slu_pkg::ST_DIGIT;
						push   = 1'b1;
						mode_d = M_PLAIN;
					end else begin
						acc_d  = {20'd0, hv};
						cnt_d  = 4'd1;
						mode_d = (mode_q == M_U4FIRST) ? M_U4DIG : M_U8DIG;
					end
				end
				M_U4DIG, M_U8DIG: begin
					if (!hok) begin
						job.status = slu_pkg::ST_DIGIT;
						push   = 1'b1;
						mode_d = M_PLAIN;
						acc_d  = '0;
						cnt_d  = '0;
						ovf_d  = 1'b0;
					end else if (hcnt >= ((mode_q == M_U4DIG) ? 4'd4 : 4'd8)) begin
						job    = encode(hacc, hovf);
						push   = 1'b1;
						mode_d = M_PLAIN;
						acc_d  = '0;
						cnt_d  = '0;
						ovf_d  = 1'b0;
					end else begin
						acc_d = hacc;
						cnt_d = hcnt;
						ovf_d = hovf;
					end
				end
				M_BRACED: begin
					if (b == CH_RBRACE || !hok) begin
						push   = 1'b1;
						mode_d = M_PLAIN;
						acc_d  = '0;
						cnt_d  = '0;
						ovf_d  = 1'b0;
						if (b == CH_RBRACE && cnt_q != 4'd0) begin
							job = encode(acc_q, ovf_q);
						end else begin
							job.status = slu_pkg::ST_DIGIT;
						end
					end else begin
						acc_d = hacc;
						cnt_d = hcnt;
						ovf_d = hovf;
					end
				end
				default: begin
					mode_d = M_PLAIN;
					acc_d  = '0;
					cnt_d  = '0;
					ovf_d  = 1'b0;
					if (b == CH_BSLASH) begin
						mode_d = M_ESC;
					end else begin
						job.bytes[0] = b;
						push = 1'b1;
					end
				end
			endcase
		end
		if (!fire) begin
			push = 1'b0;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q <= M_PLAIN;
			acc_q  <= '0;
			cnt_q  <= '0;
			ovf_q  <= 1'b0;
		end else if (fire) begin
			mode_q <= mode_d;
			acc_q  <= acc_d;
			cnt_q  <= cnt_d;
			ovf_q  <= ovf_d;
		end
	end

	// end mark always returns to plain text
	assert property (@(posedge clk) disable iff (!arst_n)
		fire && in_item.end_of_literal |=> mode_q == M_PLAIN)
		else $error("parser not in plain text after end mark");

	// a status job never carries text
	assert property (@(posedge clk) disable iff (!arst_n)
		push && job.status != slu_pkg::ST_OK |-> job.last_idx == 2'd0 && job.bytes == '0)
		else $error("status job carries text");

endmodule

// File: design/slu_queue.sv
// job queue between parser front end and output back end
// depends on slu_pkg
module slu_queue (
	input  logic          clk,
	input  logic          arst_n,
	input  logic          push,
	input  slu_pkg::job_t push_job,
	output logic          full,
	input  logic          pop,
	output logic          head_valid,
	output slu_pkg::job_t head_job
);

	slu_pkg::job_t                   mem_q [slu_pkg::QDepth];
	logic [slu_pkg::QPtrW-1:0]       wr_ptr_q;
	logic [slu_pkg::QPtrW-1:0]       rd_ptr_q;
	logic [slu_pkg::QCntW-1:0]       count_q;

	assign full       = (count_q == slu_pkg::QCntW'(slu_pkg::QDepth));
	assign head_valid = (count_q != '0);
	assign head_job   = mem_q[rd_ptr_q];

	always_ff @(posedge clk) begin
		if (push) begin
			mem_q[wr_ptr_q] <= push_job;
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			wr_ptr_q <= '0;
			rd_ptr_q <= '0;
			count_q  <= '0;
		end else begin
			if (push) begin
				wr_ptr_q <= wr_ptr_q + 1'b1;
			end
			if (pop) begin
				rd_ptr_q <= rd_ptr_q + 1'b1;
			end
			case ({push, pop})
				2'b10:   count_q <= count_q + 1'b1;
				2'b01:   count_q <= count_q - 1'b1;
				default: count_q <= count_q;
			endcase
		end
	end

	assert property (@(posedge clk) disable iff (!arst_n) push |-> !full)
		else $error("push into full queue");

	assert property (@(posedge clk) disable iff (!arst_n) pop |-> head_valid)
		else $error("pop from empty queue");

endmodule

// File: design/slu_back.sv
// back end: walks each job one byte at a time into the output register
// depends on slu_pkg
module slu_back (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               head_valid,
	input  slu_pkg::job_t      head_job,
	output logic               pop,
	output logic               out_valid,
	input  logic               out_ready,
	output slu_pkg::out_item_t out_item
);

	logic [1:0]         idx_q;
	logic               out_valid_q;
	slu_pkg::out_item_t out_q;
	logic               load;
	logic               at_last;

	assign load      = head_valid && (!out_valid_q || out_ready);
	assign at_last   = (idx_q == head_job.last_idx);
	assign pop       = load && at_last;
	assign out_valid = out_valid_q;
	assign out_item  = out_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			idx_q       <= '0;
			out_valid_q <= 1'b0;
		end else begin
			if (load) begin
				idx_q       <= at_last ? 2'd0 : idx_q + 2'd1;
				out_valid_q <= 1'b1;
			end else if (out_ready) begin
				out_valid_q <= 1'b0;
			end
		end
	end

	// payload register
	always_ff @(posedge clk) begin
		if (load) begin
			out_q.out_byte    <= head_job.bytes[idx_q];
			out_q.last_of_run <= at_last;
			out_q.status      <= head_job.status;
		end
	end

	// mid-job position only exists while the job is still queued
	assert property (@(posedge clk) disable iff (!arst_n)
		idx_q != 2'd0 |-> head_valid && idx_q <= head_job.last_idx)
		else $error("byte index runs past its job");

	assert property (@(posedge clk) disable iff (!arst_n)
		out_valid_q && out_q.status != slu_pkg::ST_OK |-> out_q.last_of_run)
		else $error("status result not last of run");

endmodule

// File: design/string_literal_unescape_utf8.sv
// top level of the string literal unescape decoder with utf-8 output
// depends on slu_pkg, slu_front, slu_queue, slu_back
//
// Decodes the body of a quoted literal one byte per input item: plain bytes
// pass through, C escapes (\a \b \e \f \n \r \t \v \" \' \\, \x with two hex
// digits, octal up to three digits) give one byte, and \u, \U and the braced
// forms give a code point sent as 1 to 4 utf-8 bytes. Bad escapes, bad
// digits, code points above 10FFFF and an escape cut off by end_of_literal
// give one result with a nonzero status and out_byte 0. An item with
// end_of_literal set flushes a pending octal escape. The block takes one
// item per cycle as long as its 4-deep job queue has room; each item that
// yields results puts one job in the queue, and the output register drains
// one result per cycle while out_ready is high, so a 4-byte utf-8 sequence
// holds the output side while the queue keeps taking input. An accepted
// item's job is written into the queue, and its first result then loads
// into the output register from the head of the queue.
module string_literal_unescape_utf8 (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               in_valid,
	output logic               in_ready,
	input  slu_pkg::in_item_t  in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output slu_pkg::out_item_t out_item
);

	// front to queue
	logic          push;
	slu_pkg::job_t push_job;
	logic          q_full;

	// queue to back
	logic          pop;
	logic          head_valid;
	slu_pkg::job_t head_job;

	// parser: classifies each item and builds its job
	slu_front u_front (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.q_full   (q_full),
		.push     (push),
		.job      (push_job)
	);

	// decouples parser from a stalled output
	slu_queue u_queue (
		.clk        (clk),
		.arst_n     (arst_n),
		.push       (push),
		.push_job   (push_job),
		.full       (q_full),
		.pop        (pop),
		.head_valid (head_valid),
		.head_job   (head_job)
	);

	// serializer and output register
	slu_back u_back (
		.clk        (clk),
		.arst_n     (arst_n),
		.head_valid (head_valid),
		.head_job   (head_job),
		.pop        (pop),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item)
	);

endmodule

// File: dv/string_literal_unescape_utf8_tb.sv
// self-checking testbench for string_literal_unescape_utf8
// holds a scoreboard class with its own escape decoder and the top module
// depends on slu_pkg and the string_literal_unescape_utf8 rtl

// where the decoder stands inside a literal body
typedef enum logic [3:0] {
	PM_PLAIN,
	PM_ESC,
	PM_HEX_HI,
	PM_HEX_LO,
	PM_OCT_ONE,
	PM_OCT_TWO,
	PM_U4_FIRST,
	PM_U4_DIGIT,
	PM_U8_FIRST,
	PM_U8_DIGIT,
	PM_BRACED
} parse_mode_t;

class unescape_scoreboard;
	parse_mode_t        mode;
	logic [23:0]        code_acc;
	logic [3:0]         digits;
	logic               overflow;
	slu_pkg::out_item_t pending_results[$];
	slu_pkg::out_item_t item_results[$];
	int                 mismatches;

	function new();
		clear_escape();
		mismatches = 0;
	endfunction

	function void clear_escape();
		mode     = PM_PLAIN;
		code_acc = '0;
		digits   = '0;
		overflow = 1'b0;
	endfunction

	function int hex_value(logic [7:0] b);
		if (b >= "0" && b <= "9") return b - "0";
		if (b >= "A" && b <= "F") return b - "A" + 10;
		if (b >= "a" && b <= "f") return b - "a" + 10;
		return -1;
	endfunction

	function void put(logic [7:0] b, slu_pkg::status_t st);
		if (item_results.size() < 4)
			item_results.push_back('{out_byte: b, last_of_run: 1'b0, status: st});
	endfunction

	function void fail(slu_pkg::status_t st);
		put(8'h00, st);
		clear_escape();
	endfunction

	// nonzero top nibble shifted out means the value no longer fits
	function void add_hex(int d);
		if (code_acc[23:20] != 4'h0) overflow = 1'b1;
		code_acc = {code_acc[19:0], 4'(d)};
		if (digits != 4'hf) digits++;
	endfunction

	// code point out as utf-8, one to four bytes
	function void emit_code();
		logic [23:0] cp;
		cp = code_acc;
		if (overflow || cp > 24'h10ffff) begin
			fail(slu_pkg::ST_LARGE);
			return;
		end
		if (cp <= 24'h7f) begin
			put(cp[7:0], slu_pkg::ST_OK);
		end else if (cp <= 24'h7ff) begin
			put({3'b110, cp[10:6]}, slu_pkg::ST_OK);
			put({2'b10, cp[5:0]}, slu_pkg::ST_OK);
		end else if (cp <= 24'hffff) begin
			put({4'b1110, cp[15:12]}, slu_pkg::ST_OK);
			put({2'b10, cp[11:6]}, slu_pkg::ST_OK);
			put({2'b10, cp[5:0]}, slu_pkg::ST_OK);
		end else begin
			put({5'b11110, cp[20:18]}, slu_pkg::ST_OK);
			put({2'b10, cp[17:12]}, slu_pkg::ST_OK);
			put({2'b10, cp[11:6]}, slu_pkg::ST_OK);
			put({2'b10, cp[5:0]}, slu_pkg::ST_OK);
		end
		clear_escape();
	endfunction

	function void plain_byte(logic [7:0] b);
		clear_escape();
		if (b == "\\") mode = PM_ESC;
		else put(b, slu_pkg::ST_OK);
	endfunction

	function void escape_byte(logic [7:0] b);
		clear_escape();
		case (b)
			"x", "X": mode = PM_HEX_HI;
			"0", "1", "2", "3": begin
				code_acc = 24'(b - "0");
				mode = PM_OCT_ONE;
			end
			"u": mode = PM_U4_FIRST;
			"U": mode = PM_U8_FIRST;
			"a": put(8'h07, slu_pkg::ST_OK);
			"b": put(8'h08, slu_pkg::ST_OK);
			"e": put(8'h1b, slu_pkg::ST_OK);
			"f": put(8'h0c, slu_pkg::ST_OK);
			"n": put(8'h0a, slu_pkg::ST_OK);
			"r": put(8'h0d, slu_pkg::ST_OK);
			"t": put(8'h09, slu_pkg::ST_OK);
			"v": put(8'h0b, slu_pkg::ST_OK);
			"\"", "'", "\\": put(b, slu_pkg::ST_OK);
			default: fail(slu_pkg::ST_UNKNOWN);
		endcase
	endfunction

	// works out every result of one accepted item and queues them
	function void decode_item(slu_pkg::in_item_t it);
		logic [7:0] b;
		int d;
		slu_pkg::out_item_t r;
		b = it.in_byte;
		d = hex_value(b);
		item_results.delete();
		if (it.end_of_literal) begin
			if (mode == PM_PLAIN) begin
				clear_escape();
			end else if (mode == PM_OCT_ONE || mode == PM_OCT_TWO) begin
				put(code_acc[7:0], slu_pkg::ST_OK);
				clear_escape();
			end else begin
				fail(slu_pkg::ST_UNTERM);
			end
		end else begin
			case (mode)
				PM_ESC: escape_byte(b);
				PM_HEX_HI: begin
					if (d < 0) begin
						fail(slu_pkg::ST_DIGIT);
					end else begin
						code_acc = 24'(d);
						mode = PM_HEX_LO;
					end
				end
				PM_HEX_LO: begin
					if (d < 0) begin
						fail(slu_pkg::ST_DIGIT);
					end else begin
						put({code_acc[3:0], 4'(d)}, slu_pkg::ST_OK);
						clear_escape();
					end
				end
				PM_OCT_ONE, PM_OCT_TWO: begin
					if (b >= "0" && b <= "7") begin
						code_acc = code_acc * 8 + 24'(b - "0");
						if (mode == PM_OCT_ONE) begin
							mode = PM_OCT_TWO;
						end else begin
							put(code_acc[7:0], slu_pkg::ST_OK);
							clear_escape();
						end
					end else begin
						// the byte that ends the octal escape is decoded too
						put(code_acc[7:0], slu_pkg::ST_OK);
						plain_byte(b);
					end
				end
				PM_U4_FIRST, PM_U8_FIRST: begin
					if (b == "{") begin
						clear_escape();
						mode = PM_BRACED;
					end else if (d < 0) begin
						fail(slu_pkg::ST_DIGIT);
					end else begin
						r.status = (mode == PM_U4_FIRST) ? slu_pkg::ST_OK : slu_pkg::ST_UNKNOWN;
						clear_escape();
						add_hex(d);
						mode = (r.status == slu_pkg::ST_OK) ? PM_U4_DIGIT : PM_U8_DIGIT;
					end
				end
				PM_U4_DIGIT, PM_U8_DIGIT: begin
					if (d < 0) begin
						fail(slu_pkg::ST_DIGIT);
					end else begin
						add_hex(d);
						if (digits >= ((mode == PM_U4_DIGIT) ? 4'd4 : 4'd8)) emit_code();
					end
				end
				PM_BRACED: begin
					if (b == "}") begin
						if (digits == 4'h0) fail(slu_pkg::ST_DIGIT);
						else emit_code();
					end else if (d < 0) begin
						fail(slu_pkg::ST_DIGIT);
					end else begin
						add_hex(d);
					end
				end
				default: plain_byte(b);
			endcase
		end
		if (item_results.size() > 0) begin
			r = item_results.pop_back();
			r.last_of_run = 1'b1;
			item_results.push_back(r);
		end
		foreach (item_results[i]) pending_results.push_back(item_results[i]);
	endfunction

	function void check_result(slu_pkg::out_item_t got);
		slu_pkg::out_item_t want;
		if (pending_results.size() == 0) begin
			$display("%0t: unexpected result, out_byte %h last_of_run %b status %0d",
				$time, got.out_byte, got.last_of_run, got.status);
			mismatches++;
			return;
		end
		want = pending_results.pop_front();
		if (got.out_byte !== want.out_byte) begin
			$display("%0t: out_byte mismatch, expected %h actual %h",
				$time, want.out_byte, got.out_byte);
			mismatches++;
		end
		if (got.last_of_run !== want.last_of_run) begin
			$display("%0t: last_of_run mismatch, expected %b actual %b",
				$time, want.last_of_run, got.last_of_run);
			mismatches++;
		end
		if (got.status !== want.status) begin
			$display("%0t: status mismatch, expected %0d actual %0d",
				$time, want.status, got.status);
			mismatches++;
		end
	endfunction
endclass

module string_literal_unescape_utf8_tb;

	// total item count and where each side runs without idling
	localparam int RandomItems = 330;
	localparam int QuietFrom   = 120;
	localparam int QuietTo     = 200;
	// long receiver hold-off that fills the job queue
	localparam int HoldAt      = 150;
	localparam int HoldLen     = 64;
	localparam int RxQuietFrom = 260;
	localparam int RxQuietTo   = 360;
	// cycles with no item moving on either side before giving up
	localparam int StallLimit  = 1000;
	localparam int DrainCycles = 10;

	logic               clk;
	logic               arst_n;
	logic               in_valid;
	logic               in_ready;
	slu_pkg::in_item_t  in_item;
	logic               out_valid;
	logic               out_ready;
	slu_pkg::out_item_t out_item;

	unescape_scoreboard sb;
	slu_pkg::in_item_t  tx_bytes[$];
	int                 sent;
	int                 stall_cycles;
	int                 rx_cycle;

	string_literal_unescape_utf8 u_top (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_item   (in_item),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_item  (out_item)
	);

	always begin
		clk = 1'b0;
		#10;
		clk = 1'b1;
		#10;
	end

	// ---------------------------------------------------------------
	// stimulus building: bytes of the literal body go into tx_bytes,
	// send_queued then hands them to the block one item at a time
	// ---------------------------------------------------------------

	function automatic void push_byte(logic [7:0] b);
		tx_bytes.push_back('{in_byte: b, end_of_literal: 1'b0});
	endfunction

	// end mark with a junk byte, the block must ignore it
	function automatic void push_end();
		tx_bytes.push_back('{in_byte: 8'($urandom_range(255)), end_of_literal: 1'b1});
	endfunction

	function automatic void push_text(string s);
		for (int i = 0; i < s.len(); i++) push_byte(s[i]);
	endfunction

	// hex letters come out in either case
	function automatic logic [7:0] hex_char(logic [3:0] n);
		if (n < 4'd10) return "0" + 8'(n);
		return ($urandom_range(1) ? "a" : "A") + 8'(n) - 8'd10;
	endfunction

	// most significant digit first; digits above bit 31 come out as zeros
	function automatic void push_hex(logic [31:0] v, int n);
		for (int i = n - 1; i >= 0; i--) push_byte(hex_char(4'(v >> (4 * i))));
	endfunction

	// code points spread over every utf-8 length, surrogates, the limit
	// and beyond it
	function automatic logic [31:0] pick_code();
		case ($urandom_range(9))
			0: return $urandom_range(32'h7f);
			1: return $urandom_range(32'h7ff, 32'h80);
			2: return $urandom_range(32'hffff, 32'h800);
			3: return $urandom_range(32'h10ffff, 32'h10000);
			4: return $urandom_range(32'hdfff, 32'hd800);
			5: return $urandom_range(32'hffffff, 32'h110000);
			6: return $urandom();
			default: begin
				case ($urandom_range(10))
					0: return 32'h0;
					1: return 32'h7f;
					2: return 32'h80;
					3: return 32'h7ff;
					4: return 32'h800;
					5: return 32'hffff;
					6: return 32'h10000;
					7: return 32'h10ffff;
					8: return 32'h110000;
					9: return 32'hffffff;
					default: return 32'h1000000;
				endcase
			end
		endcase
	endfunction

	// one well-formed escape with random content, a plain byte, an end
	// mark, or a broken escape
	task automatic queue_random_token();
		string simple;
		string starts;
		logic [31:0] cp;
		int nd;
		int pick;
		logic [7:0] s;
		simple = "abefnrtv\"'\\";
		starts = "xXuU0123";
		pick = $urandom_range(99);
		if (pick < 25) begin
			push_byte(8'($urandom_range(255)));
		end else if (pick < 35) begin
			push_byte("\\");
			push_byte(simple[$urandom_range(simple.len() - 1)]);
		end else if (pick < 45) begin
			push_byte("\\");
			push_byte($urandom_range(1) ? "x" : "X");
			push_hex($urandom_range(255), 2);
		end else if (pick < 55) begin
			// octal of one to three digits, ended by whatever follows
			push_byte("\\");
			push_byte("0" + 8'($urandom_range(3)));
			repeat ($urandom_range(2)) push_byte("0" + 8'($urandom_range(7)));
		end else if (pick < 65) begin
			push_text("\\u");
			push_hex(pick_code(), 4);
		end else if (pick < 73) begin
			push_text("\\U");
			push_hex(pick_code(), 8);
		end else if (pick < 83) begin
			// braced form: sometimes empty, sometimes long runs of leading
			// zeros that saturate the digit count
			cp = pick_code();
			nd = 1;
			while (nd < 8 && (cp >> (4 * nd)) != 0) nd++;
			case ($urandom_range(9))
				0: nd = 0;
				1: nd += $urandom_range(16, 6);
				default: nd += $urandom_range(2);
			endcase
			push_byte("\\");
			push_byte($urandom_range(1) ? "u" : "U");
			push_byte("{");
			push_hex(cp, nd);
			push_byte("}");
		end else if (pick < 89) begin
			push_end();
		end else begin
			// escape cut short by a random byte or by the end mark
			push_byte("\\");
			s = $urandom_range(3) ? starts[$urandom_range(starts.len() - 1)]
				: 8'($urandom_range(255));
			push_byte(s);
			if ((s == "u" || s == "U") && $urandom_range(1)) push_byte("{");
			if ($urandom_range(1)) push_byte(hex_char(4'($urandom_range(15))));
			if ($urandom_range(1)) push_end();
			else push_byte(8'($urandom_range(255)));
		end
	endtask

	// offers each queued item until taken, with a one-cycle gap now and
	// then except inside the quiet stretch
	task automatic send_queued();
		slu_pkg::in_item_t it;
		while (tx_bytes.size() != 0) begin
			it = tx_bytes.pop_front();
			if (!(sent >= QuietFrom && sent < QuietTo) && $urandom_range(99) < 9) begin
				in_valid <= 1'b0;
				@(posedge clk);
			end
			in_valid <= 1'b1;
			in_item  <= it;
			do @(posedge clk); while (!in_ready);
			sent++;
		end
	endtask

	// ---------------------------------------------------------------
	// receiver: random stalls, one quiet stretch, one long hold-off
	// during which the sender keeps offering and the block must back up
	// ---------------------------------------------------------------
	initial begin
		out_ready <= 1'b0;
		rx_cycle = 0;
		@(posedge clk);
		while (!arst_n) @(posedge clk);
		forever begin
			@(posedge clk);
			rx_cycle++;
			if (rx_cycle == HoldAt) begin
				out_ready <= 1'b0;
				repeat (HoldLen) @(posedge clk);
				rx_cycle += HoldLen;
			end else begin
				out_ready <= (rx_cycle >= RxQuietFrom && rx_cycle < RxQuietTo)
					|| ($urandom_range(99) >= 9);
			end
		end
	end

	// ---------------------------------------------------------------
	// monitor: inputs noted before outputs are checked, both sampled at
	// the edge; the watchdog ends a run where nothing moves any more
	// ---------------------------------------------------------------
	always @(posedge clk) begin
		if (arst_n) begin
			if (in_valid && in_ready) sb.decode_item(in_item);
			if (out_valid && out_ready) sb.check_result(out_item);
			if ((in_valid && in_ready) || (out_valid && out_ready)) stall_cycles = 0;
			else stall_cycles++;
			if (stall_cycles >= StallLimit) begin
				$display("%0t: no item moved for %0d cycles", $time, StallLimit);
				$display("FAIL");
				$finish;
			end
		end
	end

	initial begin
		sb = new();
		sent = 0;
		stall_cycles = 0;
		arst_n   <= 1'b0;
		in_valid <= 1'b0;
		in_item  <= '0;
		repeat (9) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed: byte extremes, a simple escape, upper-case \X with
		// mixed-case digits, largest octal, an octal start digit out of
		// range, octal ended by a plain byte, empty braces, octal flushed
		// by the end mark, hex escape cut off by the end mark, end mark
		// in plain text
		push_byte(8'h00);
		push_byte(8'hff);
		push_text("\\n\\XfF\\377\\7\\1g\\u{}\\2");
		push_end();
		push_text("\\x");
		push_end();
		push_end();
		send_queued();

		// random: mostly well-formed escapes with random content
		while (sent < RandomItems) begin
			queue_random_token();
			send_queued();
		end
		in_valid <= 1'b0;

		// wait for every expected result, then give stray results a chance
		while (sb.pending_results.size() != 0) @(posedge clk);
		repeat (DrainCycles) @(posedge clk);

		if (sb.mismatches == 0 && sb.pending_results.size() == 0) begin
			$display("PASS");
		end else begin
			$display("FAIL");
		end
		$finish;
	end

endmodule

// File: sim.f
design/slu_pkg.sv
design/slu_front.sv
design/slu_queue.sv
design/slu_back.sv
design/string_literal_unescape_utf8.sv
dv/string_literal_unescape_utf8_tb.sv
